/* design/fbs_pkg.sv */
// ----------------------------------------------------------------------------
// fbs_pkg: shared types and constants of the frame buffer blitter and scanner
// Operation codes, driver command addresses, init groups, register indexes,
// the sequencer state type and the beat descriptor between the two output
// stages.
// ----------------------------------------------------------------------------
`default_nettype none

package fbs_pkg;

   // Operation codes carried by req_func.
   localparam logic [2:0] FN_CLEAR   = 3'd0;
   localparam logic [2:0] FN_SET     = 3'd1;
   localparam logic [2:0] FN_CLR     = 3'd2;
   localparam logic [2:0] FN_DRAW    = 3'd3;
   localparam logic [2:0] FN_ERASE   = 3'd4;
   localparam logic [2:0] FN_REFRESH = 3'd5;
   localparam logic [2:0] FN_INIT    = 3'd6;

   // Driver command register addresses and the fixed shutdown data.
   localparam logic [3:0] CMD_DECODE     = 4'h9;
   localparam logic [3:0] CMD_INTENSITY  = 4'hA;
   localparam logic [3:0] CMD_SCAN_LIMIT = 4'hB;
   localparam logic [3:0] CMD_SHUTDOWN   = 4'hC;
   localparam logic [7:0] SHUTDOWN_RUN   = 8'h01;

   // Pixel mask of the leftmost column in a byte.
   localparam logic [7:0] LEFT_PIXEL = 8'h80;

   // Order of the command groups in the init sequence.
   localparam logic [1:0] GRP_SHUTDOWN   = 2'd0;
   localparam logic [1:0] GRP_DECODE     = 2'd1;
   localparam logic [1:0] GRP_INTENSITY  = 2'd2;
   localparam logic [1:0] GRP_SCAN_LIMIT = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BRIGHTNESS    = 2'd0;
   localparam logic [1:0] CSR_SCAN_ROWS     = 2'd1;
   localparam logic [1:0] CSR_DECODE_SELECT = 2'd2;

   localparam logic [2:0] LAST_ROW = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_REFRESH,
      ST_INIT
   } fsm_state_type;

   // Result of the shared pixel unit.
   typedef struct packed {
      logic       hit;
      logic [7:0] mask;
   } pix_res_type;

   // One beat on its way from the sequencer to the output register.
   typedef struct packed {
      logic       strobe;
      logic [3:0] reg_addr;
      logic [7:0] data;
      logic [2:0] slot;
      logic       latch;
      logic       last;
      logic       from_store;
      logic       entry_valid;
   } beat_type;

endpackage

`default_nettype wire

/* design/fbs_ram.sv */
// ----------------------------------------------------------------------------
// fbs_ram: generic single write port, single read port RAM
// One write and one read a cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/fbs_pix.sv */
// ----------------------------------------------------------------------------
// fbs_pix: shared pixel address unit
// Clips a (column, row) pair against the display and maps it to a store
// byte address and a bit mask inside that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fbs_pix #(
   parameter int NUM_DEVICES     = 8,
   parameter int DISPLAY_COLUMNS = 64
) (
   input  wire logic [7:0]                         col,
   input  wire logic signed [7:0]                  row,
   output logic [$clog2(8*NUM_DEVICES)-1:0]        addr,
   output fbs_pkg::pix_res_type                    res
);

   localparam int AW = $clog2(8 * NUM_DEVICES);

   logic row_ok;
   logic col_ok;

   assign row_ok = !row[7] && (row[6:3] == 4'b0000);
   assign col_ok = (32'(col) < DISPLAY_COLUMNS) && (32'(col[7:3]) < NUM_DEVICES);

   assign addr     = AW'(32'(row[2:0]) * NUM_DEVICES + 32'(col[7:3]));
   assign res.hit  = row_ok && col_ok;
   assign res.mask = fbs_pkg::LEFT_PIXEL >> col[2:0];

endmodule

`default_nettype wire

/* design/mono_framebuffer_blit_scan.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_blit_scan: one-bit frame store with LED driver scan-out
// Blits pixels and row segments into an 8-row frame store and streams the
// store, or the driver init sequence, as (address, data) pairs.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; busy stays high
// until its work is done. Clear-all and unused codes return straight to
// idle. Pixel operations run the shared pixel unit once per pixel: a pixel
// inside the display passes a store read state, then a merged write state,
// and a clipped one only the read state.
// Refresh reads one store byte a cycle and emits 8*NUM_DEVICES beats on
// consecutive cycles through the stage one and output registers; init emits
// 4*NUM_DEVICES beats the same way. The store read port sets that rate.
// Each beat appears on the rsp_ ports for one cycle with rsp_strobe high;
// the receiver cannot stall. The next operation may be taken while the last
// two beats are still in the output stages.
// The CSR channel is always ready and should only be written while idle.
// Reset clears the frame store at once through per-byte valid flags, so no
// clearing pass is needed, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_blit_scan #(
   parameter int NUM_DEVICES     = 8,
   parameter int DISPLAY_COLUMNS = 64,
   parameter int MAX_ROW_WIDTH   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_func,
   input  wire logic signed [7:0] req_x_pos,
   input  wire logic signed [7:0] req_y_pos,
   input  wire logic [4:0]        req_width,
   input  wire logic [15:0]       req_row_bits,

   output logic                   rsp_strobe,
   output logic [3:0]             rsp_reg_addr,
   output logic [7:0]             rsp_reg_data,
   output logic [2:0]             rsp_device_slot,
   output logic                   rsp_latch,
   output logic                   rsp_last,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);

   localparam int DEPTH = 8 * NUM_DEVICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int WW    = $clog2(MAX_ROW_WIDTH + 1);

   fbs_pkg::fsm_state_type state_ff, state_in;

   logic [7:0]        x_ff, x_in;
   logic signed [7:0] y_ff, y_in;
   logic [15:0]       bits_ff, bits_in;
   logic [WW-1:0]     n_ff, n_in;
   logic [WW-1:0]     i_ff, i_in;
   logic [AW-1:0]     a_ff, a_in;
   logic [DW-1:0]     d_ff, d_in;
   logic [2:0]        r_ff, r_in;
   logic [DEPTH-1:0]  vld_ff, vld_in;

   logic [3:0] bright_ff;
   logic [2:0] scan_ff;
   logic [7:0] decode_ff;

   fbs_pkg::beat_type s1_ff, s1_in;

   logic       rsp_strobe_ff;
   logic [3:0] rsp_addr_ff;
   logic [7:0] rsp_data_ff;
   logic [2:0] rsp_slot_ff;
   logic       rsp_latch_ff;
   logic       rsp_last_ff;

   logic                 accept;
   logic [WW-1:0]        width_sat;
   logic [7:0]           pix_col;
   logic [AW-1:0]        pix_addr;
   fbs_pkg::pix_res_type pix_res;
   logic                 pix_done;
   logic                 dev_last;
   logic [AW-1:0]        ram_raddr;
   logic [7:0]           ram_q;
   logic                 ram_we;
   logic [7:0]           old_byte;
   logic [7:0]           new_byte;

   // ------------------------------------------------------------------------
   // Shared pixel unit and frame store

   assign pix_col = x_ff + 8'(i_ff);

   fbs_pix #(
      .NUM_DEVICES     (NUM_DEVICES),
      .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
   ) u_pix (
      .col  (pix_col),
      .row  (y_ff),
      .addr (pix_addr),
      .res  (pix_res)
   );

   assign ram_raddr = (state_ff == fbs_pkg::ST_REFRESH) ? a_ff : pix_addr;
   assign ram_we    = (state_ff == fbs_pkg::ST_PIX_WR);

   // A byte never written since the last clear reads as zero.
   assign old_byte = vld_ff[pix_addr] ? ram_q : 8'h00;
   assign new_byte = bits_ff[15] ? (old_byte | pix_res.mask)
                                 : (old_byte & ~pix_res.mask);

   fbs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pix_addr),
      .wr_data (new_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // ------------------------------------------------------------------------
   // Sequencer

   assign busy      = (state_ff != fbs_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign width_sat = (32'(req_width) > MAX_ROW_WIDTH) ? WW'(MAX_ROW_WIDTH)
                                                       : WW'(req_width);
   assign pix_done  = ((WW+1)'(i_ff) + (WW+1)'(1)) == (WW+1)'(n_ff);
   assign dev_last  = (32'(d_ff) == NUM_DEVICES - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func inside {fbs_pkg::FN_SET, fbs_pkg::FN_CLR}) begin
                  state_in = fbs_pkg::ST_PIX_RD;
               end else if (req_func inside {fbs_pkg::FN_DRAW, fbs_pkg::FN_ERASE}) begin
                  state_in = (width_sat == '0) ? fbs_pkg::ST_IDLE : fbs_pkg::ST_PIX_RD;
               end else if (req_func == fbs_pkg::FN_REFRESH) begin
                  state_in = fbs_pkg::ST_REFRESH;
               end else if (req_func == fbs_pkg::FN_INIT) begin
                  state_in = fbs_pkg::ST_INIT;
               end
            end
         end
         fbs_pkg::ST_PIX_RD: begin
            if (pix_res.hit) begin
               state_in = fbs_pkg::ST_PIX_WR;
            end else if (pix_done) begin
               state_in = fbs_pkg::ST_IDLE;
            end
         end
         fbs_pkg::ST_PIX_WR: begin
            state_in = pix_done ? fbs_pkg::ST_IDLE : fbs_pkg::ST_PIX_RD;
         end
         fbs_pkg::ST_REFRESH: begin
            if (dev_last && (r_ff == fbs_pkg::LAST_ROW)) begin
               state_in = fbs_pkg::ST_IDLE;
            end
         end
         fbs_pkg::ST_INIT: begin
            if (dev_last && (r_ff[1:0] == fbs_pkg::GRP_SCAN_LIMIT)) begin
               state_in = fbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      bits_in = bits_ff;
      n_in    = n_ff;
      i_in    = i_ff;
      a_in    = a_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      vld_in  = vld_ff;
      s1_in   = '0;

      case (state_ff)
         fbs_pkg::ST_IDLE: begin
            if (accept) begin
               x_in = req_x_pos;
               y_in = req_y_pos;
               i_in = '0;
               a_in = '0;
               d_in = '0;
               r_in = '0;
               n_in = width_sat;
               // The pixel value rides in the top bit and shifts out one per
               // pixel, so pixels past the bitmap draw as cleared.
               case (req_func)
                  fbs_pkg::FN_SET: begin
                     n_in    = WW'(1);
                     bits_in = 16'h8000;
                  end
                  fbs_pkg::FN_CLR: begin
                     n_in    = WW'(1);
                     bits_in = 16'h0000;
                  end
                  fbs_pkg::FN_DRAW: begin
                     bits_in = req_row_bits;
                  end
                  fbs_pkg::FN_CLEAR: begin
                     vld_in = '0;
                  end
                  default: begin
                     bits_in = 16'h0000;
                  end
               endcase
            end
         end
         fbs_pkg::ST_PIX_RD: begin
            if (!pix_res.hit) begin
               i_in    = i_ff + WW'(1);
               bits_in = bits_ff << 1;
            end
         end
         fbs_pkg::ST_PIX_WR: begin
            i_in             = i_ff + WW'(1);
            bits_in          = bits_ff << 1;
            vld_in[pix_addr] = 1'b1;
         end
         fbs_pkg::ST_REFRESH: begin
            s1_in.strobe      = 1'b1;
            s1_in.reg_addr    = {1'b0, r_ff} + 4'd1;
            s1_in.slot        = 3'(d_ff);
            s1_in.latch       = dev_last;
            s1_in.last        = dev_last && (r_ff == fbs_pkg::LAST_ROW);
            s1_in.from_store  = 1'b1;
            s1_in.entry_valid = vld_ff[a_ff];
            a_in              = a_ff + AW'(1);
         end
         fbs_pkg::ST_INIT: begin
            s1_in.strobe = 1'b1;
            s1_in.slot   = 3'(d_ff);
            s1_in.latch  = dev_last;
            s1_in.last   = dev_last && (r_ff[1:0] == fbs_pkg::GRP_SCAN_LIMIT);
            case (r_ff[1:0])
               fbs_pkg::GRP_SHUTDOWN: begin
                  s1_in.reg_addr = fbs_pkg::CMD_SHUTDOWN;
                  s1_in.data     = fbs_pkg::SHUTDOWN_RUN;
               end
               fbs_pkg::GRP_DECODE: begin
                  s1_in.reg_addr = fbs_pkg::CMD_DECODE;
                  s1_in.data     = decode_ff;
               end
               fbs_pkg::GRP_INTENSITY: begin
                  s1_in.reg_addr = fbs_pkg::CMD_INTENSITY;
                  s1_in.data     = {4'b0000, bright_ff};
               end
               default: begin
                  s1_in.reg_addr = fbs_pkg::CMD_SCAN_LIMIT;
                  s1_in.data     = {5'b00000, scan_ff};
               end
            endcase
         end
         default: begin
            s1_in = '0;
         end
      endcase

      if ((state_ff == fbs_pkg::ST_REFRESH) || (state_ff == fbs_pkg::ST_INIT)) begin
         if (dev_last) begin
            d_in = '0;
            r_in = r_ff + 3'd1;
         end else begin
            d_in = d_ff + DW'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Registers

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbs_pkg::ST_IDLE;
         vld_ff        <= '0;
         s1_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
         bright_ff     <= 4'd5;
         scan_ff       <= 3'd7;
         decode_ff     <= 8'd0;
      end else begin
         state_ff      <= state_in;
         vld_ff        <= vld_in;
         s1_ff         <= s1_in;
         rsp_strobe_ff <= s1_ff.strobe;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fbs_pkg::CSR_BRIGHTNESS:    bright_ff <= csr_wdata[3:0];
               fbs_pkg::CSR_SCAN_ROWS:     scan_ff   <= csr_wdata[2:0];
               fbs_pkg::CSR_DECODE_SELECT: decode_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      y_ff              <= y_in;
      bits_ff           <= bits_in;
      n_ff              <= n_in;
      i_ff              <= i_in;
      a_ff              <= a_in;
      d_ff              <= d_in;
      r_ff              <= r_in;
      // The store read issued with the stage one beat lands in ram_q now.
      rsp_addr_ff       <= s1_ff.reg_addr;
      rsp_data_ff       <= s1_ff.from_store ? (s1_ff.entry_valid ? ram_q : 8'h00)
                                            : s1_ff.data;
      rsp_slot_ff       <= s1_ff.slot;
      rsp_latch_ff      <= s1_ff.latch;
      rsp_last_ff       <= s1_ff.last;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_reg_addr    = rsp_addr_ff;
   assign rsp_reg_data    = rsp_data_ff;
   assign rsp_device_slot = rsp_slot_ff;
   assign rsp_latch       = rsp_latch_ff;
   assign rsp_last        = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions

   a_last_beat_idle: assert property (@(posedge clock) disable iff (reset)
      s1_ff.strobe && s1_ff.last |-> state_ff == fbs_pkg::ST_IDLE)
      else $error("final beat issued while the sequencer is still running");

   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside an operation's beat stream");

   a_latch_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_latch |-> rsp_device_slot == 3'(NUM_DEVICES - 1))
      else $error("latch raised away from the final device slot");

   a_write_clipped: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> pix_res.hit && $past(state_ff) == fbs_pkg::ST_PIX_RD)
      else $error("store written for a clipped pixel or without a read");

endmodule

`default_nettype wire
